/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/mws_pkg.sv */
// types, constants and codes of the motor watchdog and slew supervisor
`timescale 1ns / 1ps

package mws_pkg;

   // motors supervised; the motor field is four bits wide
   localparam int MOTORS = 16;
   localparam int MotorIdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

   localparam int SilenceW = 14;
   localparam int CmdW = 16;
   localparam int TallyW = 5;
   localparam int CsrDataW = 15;

   localparam logic [SilenceW-1:0] SILENCE_MAX = 14'd10000;
   localparam logic [TallyW-1:0] TALLY_MAX = 5'd31;
   localparam logic [13:0] OFFLINE_LIMIT_RESET = 14'd200;
   localparam logic [14:0] STEP_LIMIT_RESET = 15'd5;

   // register indexes
   localparam logic [0:0] CSR_OFFLINE_LIMIT = 1'b0;
   localparam logic [0:0] CSR_STEP_LIMIT = 1'b1;

   // item kinds
   localparam logic FUNC_FEEDBACK = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   // control modes
   localparam logic [1:0] MODE_SPEED = 2'd0;
   localparam logic [1:0] MODE_TORQUE = 2'd1;
   localparam logic [1:0] MODE_POSITION = 2'd2;
   localparam logic [1:0] MODE_OTHER = 2'd3;

   // step direction codes
   localparam logic [1:0] DIR_ZERO = 2'b00;
   localparam logic [1:0] DIR_PLUS = 2'b01;
   localparam logic [1:0] DIR_MINUS_TWO = 2'b10;
   localparam logic [1:0] DIR_MINUS = 2'b11;

   // node states
   localparam logic [2:0] NODE_ACTIVE = 3'd0;
   localparam logic [2:0] NODE_IDLE = 3'd1;
   localparam logic [2:0] NODE_FAULT = 3'd2;
   localparam logic [2:0] NODE_DISCONNECTED = 3'd3;
   localparam logic [2:0] NODE_UNCHANGED = 3'd4;

   // car states
   localparam logic [1:0] CAR_FAULT = 2'd0;
   localparam logic [1:0] CAR_ESTOP = 2'd1;
   localparam logic [1:0] CAR_MOVING = 2'd2;
   localparam logic [1:0] CAR_IDLE = 2'd3;

   // fault summary
   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_SINGLE = 2'd1;
   localparam logic [1:0] FAULT_MULTIPLE = 2'd2;

   // one motor's table entry
   typedef struct packed {
      logic [SilenceW-1:0] silence;
      logic                online;
      logic [CmdW-1:0]     commanded;
      logic [CmdW-1:0]     previous;
   } entry_type;

   // captured input transaction
   typedef struct packed {
      logic              func;
      logic [3:0]        motor;
      logic [1:0]        mode;
      logic              enabled;
      logic signed [15:0] target;
      logic signed [1:0]  direction;
      logic signed [15:0] position_target;
      logic              error_nonzero;
      logic              reinit_request;
      logic              last_motor;
      logic              estop;
      logic              motion_requested;
   } item_type;

   // result transaction
   typedef struct packed {
      logic [3:0]         motor_out;
      logic signed [15:0] command;
      logic               online;
      logic [2:0]         node_state;
      logic               reinit_motor;
      logic               car_valid;
      logic [1:0]         car_state;
      logic [1:0]         fault_summary;
   } result_type;

   // update unit outcome
   typedef struct packed {
      logic              write;
      entry_type         entry;
      logic [TallyW-1:0] tally;
      result_type        result;
   } update_type;

endpackage

/* hdl/mws_req_if.sv */
// input channel carrying supervisor requests
`timescale 1ns / 1ps

interface mws_req_if;
   logic              valid;
   logic              ready;
   logic              func;
   logic [3:0]        motor;
   logic [1:0]        mode;
   logic              enabled;
   logic signed [15:0] target;
   logic signed [1:0]  direction;
   logic signed [15:0] position_target;
   logic              error_nonzero;
   logic              reinit_request;
   logic              last_motor;
   logic              estop;
   logic              motion_requested;

   modport source (
      output valid, func, motor, mode, enabled, target, direction, position_target,
             error_nonzero, reinit_request, last_motor, estop, motion_requested,
      input  ready
   );

   modport sink (
      input  valid, func, motor, mode, enabled, target, direction, position_target,
             error_nonzero, reinit_request, last_motor, estop, motion_requested,
      output ready
   );
endinterface

/* hdl/mws_rsp_if.sv */
// result channel carrying supervisor responses
`timescale 1ns / 1ps

interface mws_rsp_if;
   logic              valid;
   logic              ready;
   logic [3:0]        motor_out;
   logic signed [15:0] command;
   logic              online;
   logic [2:0]        node_state;
   logic              reinit_motor;
   logic              car_valid;
   logic [1:0]        car_state;
   logic [1:0]        fault_summary;

   modport source (
      output valid, motor_out, command, online, node_state, reinit_motor,
             car_valid, car_state, fault_summary,
      input  ready
   );

   modport sink (
      input  valid, motor_out, command, online, node_state, reinit_motor,
             car_valid, car_state, fault_summary,
      output ready
   );
endinterface

/* hdl/mws_table.sv */
// per-motor state memory with valid bits for a zero reset
`timescale 1ns / 1ps

module mws_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_en,
   input  logic [mws_pkg::MotorIdxW-1:0]       rd_addr,
   output mws_pkg::entry_type                  rd_data,
   input  logic                                wr_en,
   input  logic [mws_pkg::MotorIdxW-1:0]       wr_addr,
   input  mws_pkg::entry_type                  wr_data
);
   import mws_pkg::*;

   entry_type              mem [MOTORS];
   logic [MOTORS-1:0]      valid_ff;
   entry_type              rd_raw_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

/* hdl/mws_update.sv */
// read-modify logic: watchdog, slew limiter and sweep report
`timescale 1ns / 1ps

module mws_update (
   input  mws_pkg::item_type                item,
   input  mws_pkg::entry_type               entry,
   input  logic [13:0]                      offline_limit,
   input  logic [14:0]                      step_limit,
   input  logic [mws_pkg::TallyW-1:0]       tally,
   output mws_pkg::update_type              upd
);
   import mws_pkg::*;

   logic                   in_range;
   logic [SilenceW-1:0]    silence_inc;
   logic                   went_off;
   logic                   online_next;
   logic signed [16:0]     diff;
   logic signed [16:0]     lim;
   logic signed [16:0]     clamped;
   logic [CmdW-1:0]        step;
   logic [CmdW-1:0]        scaled;
   logic [TallyW-1:0]      tally_inc;

   assign in_range = (32'(item.motor) < MOTORS);
   assign silence_inc = (entry.silence < SILENCE_MAX) ? entry.silence + 14'd1 : entry.silence;
   assign went_off = (silence_inc > offline_limit) || item.reinit_request;
   assign online_next = entry.online && !went_off;

   // difference to last limited command, clamped to the step window
   assign diff = 17'(item.target) - 17'($signed(entry.previous));
   assign lim = $signed({2'b00, step_limit});

   always_comb begin
      if (diff > lim) begin
         clamped = lim;
      end else if (diff < -lim) begin
         clamped = -lim;
      end else begin
         clamped = diff;
      end
   end

   assign step = clamped[CmdW-1:0];

   always_comb begin
      unique case (item.direction)
         DIR_PLUS:      scaled = step;
         DIR_ZERO:      scaled = '0;
         DIR_MINUS:     scaled = -step;
         DIR_MINUS_TWO: scaled = -(step << 1);
         default:       scaled = '0;
      endcase
   end

   assign tally_inc = (!online_next && tally < TALLY_MAX) ? tally + 5'd1 : tally;

   always_comb begin
      upd = '0;
      upd.tally = tally;
      upd.entry = entry;
      upd.result.motor_out = item.motor;
      if (in_range) begin
         upd.write = 1'b1;
         if (item.func == FUNC_FEEDBACK) begin
            upd.entry.silence = '0;
            upd.entry.online = 1'b1;
            upd.result.node_state = NODE_UNCHANGED;
         end else begin
            upd.entry.silence = silence_inc;
            upd.entry.online = online_next;
            upd.result.reinit_motor = went_off;
            upd.result.node_state = NODE_UNCHANGED;
            if (online_next) begin
               unique case (item.mode)
                  MODE_POSITION: begin
                     upd.entry.commanded = item.position_target;
                  end
                  MODE_SPEED, MODE_TORQUE: begin
                     upd.result.node_state = (item.enabled && item.target != 16'sd0)
                                             ? NODE_ACTIVE : NODE_IDLE;
                     upd.entry.commanded = entry.commanded + scaled;
                     upd.entry.previous = entry.commanded + scaled;
                  end
                  default: begin
                  end
               endcase
            end else begin
               upd.entry.commanded = '0;
               upd.result.node_state = item.error_nonzero ? NODE_FAULT : NODE_DISCONNECTED;
            end
            upd.tally = tally_inc;
            // end of sweep: report and clear the tally
            if (item.last_motor) begin
               upd.result.car_valid = 1'b1;
               priority if (tally_inc == '0) begin
                  upd.result.fault_summary = FAULT_NONE;
               end else if (tally_inc == 5'd1) begin
                  upd.result.fault_summary = FAULT_SINGLE;
               end else begin
                  upd.result.fault_summary = FAULT_MULTIPLE;
               end
               priority if (tally_inc != '0) begin
                  upd.result.car_state = CAR_FAULT;
               end else if (item.estop) begin
                  upd.result.car_state = CAR_ESTOP;
               end else if (item.motion_requested) begin
                  upd.result.car_state = CAR_MOVING;
               end else begin
                  upd.result.car_state = CAR_IDLE;
               end
               upd.tally = '0;
            end
         end
         upd.result.command = upd.entry.commanded;
         upd.result.online = upd.entry.online;
      end
   end

endmodule

/* hdl/motor_watchdog_slew_supervisor_unit.sv */
// top level of the motor watchdog and slew supervisor
`timescale 1ns / 1ps

// Supervises up to MOTORS motors from one state table holding each motor's
// silence counter, online flag, current command and last slew-limited
// command. A feedback transaction clears the counter and marks the motor
// online; an update transaction ages the counter, drops the motor offline
// past offline_limit or on a reinit request, slew-limits the command in
// speed and torque modes and, on the last motor of a sweep, reports car
// state and fault summary. Each transaction issues the synchronous table
// read at acceptance, then updates, writes back and loads the result
// register once that register is free; no new transaction is taken until
// then, and req ready rises again right after the writeback. The result
// register lets a new request be accepted while an earlier response
// waits. The table needs no clearing pass after reset: per-entry valid
// bits make unwritten motors read as zero. Configuration writes are taken
// on any cycle and should be made only while the block is idle.

module motor_watchdog_slew_supervisor_unit (
   input  logic                         clock,
   input  logic                         reset,
   mws_req_if.sink                      req_chan,
   mws_rsp_if.source                    rsp_chan,
   input  logic                         csr_write_enable,
   input  logic [0:0]                   csr_index,
   input  logic [mws_pkg::CsrDataW-1:0] csr_write_data
);
   import mws_pkg::*;

   // one-hot control states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   item_type           item_ff;
   logic [13:0]        offline_limit_ff;
   logic [14:0]        step_limit_ff;
   logic [TallyW-1:0]  tally_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;

   logic               accept;
   logic               out_free;
   logic               finish;
   entry_type          rd_entry;
   update_type         upd;
   item_type           req_item;

   // gather request fields
   assign req_item.func = req_chan.func;
   assign req_item.motor = req_chan.motor;
   assign req_item.mode = req_chan.mode;
   assign req_item.enabled = req_chan.enabled;
   assign req_item.target = req_chan.target;
   assign req_item.direction = req_chan.direction;
   assign req_item.position_target = req_chan.position_target;
   assign req_item.error_nonzero = req_chan.error_nonzero;
   assign req_item.reinit_request = req_chan.reinit_request;
   assign req_item.last_motor = req_chan.last_motor;
   assign req_item.estop = req_chan.estop;
   assign req_item.motion_requested = req_chan.motion_requested;

   // one transaction in flight; result register decouples the output side
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tally_ff <= '0;
         offline_limit_ff <= OFFLINE_LIMIT_RESET;
         step_limit_ff <= STEP_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            tally_ff <= upd.tally;
         end
         // configuration writes
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_OFFLINE_LIMIT: offline_limit_ff <= csr_write_data[13:0];
               CSR_STEP_LIMIT:    step_limit_ff <= csr_write_data[14:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (finish) begin
         rsp_ff <= upd.result;
      end
   end

   // state table: read at acceptance, written back on finish
   mws_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (MotorIdxW'(req_chan.motor)),
      .rd_data (rd_entry),
      .wr_en   (finish && upd.write),
      .wr_addr (MotorIdxW'(item_ff.motor)),
      .wr_data (upd.entry)
   );

   mws_update u_update (
      .item          (item_ff),
      .entry         (rd_entry),
      .offline_limit (offline_limit_ff),
      .step_limit    (step_limit_ff),
      .tally         (tally_ff),
      .upd           (upd)
   );

   // response port
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.motor_out = rsp_ff.motor_out;
   assign rsp_chan.command = rsp_ff.command;
   assign rsp_chan.online = rsp_ff.online;
   assign rsp_chan.node_state = rsp_ff.node_state;
   assign rsp_chan.reinit_motor = rsp_ff.reinit_motor;
   assign rsp_chan.car_valid = rsp_ff.car_valid;
   assign rsp_chan.car_state = rsp_ff.car_state;
   assign rsp_chan.fault_summary = rsp_ff.fault_summary;

endmodule

/* hdl/mws_checker.sv */
// port-level checks on the supervisor and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mws_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_motor_out,
   input logic [15:0] rsp_command,
   input logic       rsp_online,
   input logic [2:0] rsp_node_state,
   input logic       rsp_reinit_motor
);
   import mws_pkg::*;

   logic offline_ok;

   // offline response shape: flag low, command zero, offline node state
   assign offline_ok = !rsp_online && rsp_command == 16'd0 &&
                       (rsp_node_state == NODE_FAULT || rsp_node_state == NODE_DISCONNECTED);

   // one transaction in flight: busy in the cycle after acceptance
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a fresh response follows an acceptance through the table read and the result register
   `ASSERT_IMPLY(a_rsp_follows_req, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

   // a motor dropped offline carries a zero command and an offline node state
   `ASSERT_IMPLY(a_reinit_offline, clock, reset, rsp_valid && rsp_reinit_motor, offline_ok)

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_motor_out) && $stable(rsp_command))

endmodule

bind motor_watchdog_slew_supervisor_unit mws_checker u_mws_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_motor_out    (rsp_chan.motor_out),
   .rsp_command      (rsp_chan.command),
   .rsp_online       (rsp_chan.online),
   .rsp_node_state   (rsp_chan.node_state),
   .rsp_reinit_motor (rsp_chan.reinit_motor)
);
